// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module of the glyph layout block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/gll_pkg.sv -----
// Types and constants of the glyph line layout block.
// Used by every module of the block; no dependencies.
package gll_pkg;

   localparam int GLYPH_COUNT = 256;
   localparam int TABLE_BITS  = 8;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [7:0] CODE_END     = 8'hFF;
   localparam logic [7:0] CODE_NEWLINE = 8'hFE;
   localparam logic [7:0] CODE_UNSUP   = 8'hF7;
   localparam int         LINE_STEP    = 16;
   localparam logic [7:0] MAX_WIDTH    = 8'd16;

   localparam logic OP_GLYPH = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_START_X = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_Y = 1'b1;

   typedef enum logic [2:0] {
      ST_PLACED      = 3'd0,
      ST_LINE_BREAK  = 3'd1,
      ST_END         = 3'd2,
      ST_UNSUPPORTED = 3'd3,
      ST_INVALID     = 3'd4,
      ST_IGNORED     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CLS_GLYPH,
      CLS_NEWLINE,
      CLS_END,
      CLS_UNSUP
   } cls_type;

   typedef struct packed {
      logic       op;
      logic [7:0] code;
      logic [7:0] width_value;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         glyph;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [4:0]         glyph_width;
      logic               truncated;
   } rsp_type;

   // A classified request with its looked-up width.
   typedef struct packed {
      cls_type    cls;
      logic [7:0] code;
      logic [7:0] width;
      logic       first;
      logic       last;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

endpackage

// ----- hdl/gll_front.sv -----
// Front end: accepts requests, keeps the glyph width table and classifies glyph codes.
// Depends on gll_pkg.
module gll_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gll_pkg::req_type  req_data,
   output gll_pkg::link_type fwd,
   input  logic              q_ready
);
   import gll_pkg::*;

   logic [7:0]             mem [GLYPH_COUNT];
   logic [GLYPH_COUNT-1:0] tvld_ff;
   logic [7:0]             rd_ff;
   logic                   rdv_ff;
   logic                   f_valid_ff;
   logic                   f_valid_in;
   cls_type                cls_ff;
   cls_type                cls_in;
   logic [7:0]             code_ff;
   logic                   first_ff;
   logic                   last_ff;
   logic                   accept;
   logic                   acc_glyph;
   logic                   acc_write;

   assign req_stall = f_valid_ff & ~q_ready;
   assign accept    = req_valid & ~req_stall;
   assign acc_glyph = accept & (req_data.op == OP_GLYPH);
   assign acc_write = accept & (req_data.op == OP_WRITE);

   // A held item leaves as soon as the queue has room.
   assign f_valid_in = acc_glyph | (f_valid_ff & ~q_ready);

   always_comb begin
      priority if (req_data.code == CODE_END) begin
         cls_in = CLS_END;
      end else if (req_data.code == CODE_NEWLINE) begin
         cls_in = CLS_NEWLINE;
      end else if (req_data.code >= CODE_UNSUP) begin
         cls_in = CLS_UNSUP;
      end else begin
         cls_in = CLS_GLYPH;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_write) begin
         mem[req_data.code[TABLE_BITS-1:0]] <= req_data.width_value;
      end
      if (acc_glyph) begin
         rd_ff    <= mem[req_data.code[TABLE_BITS-1:0]];
         cls_ff   <= cls_in;
         code_ff  <= req_data.code;
         first_ff <= req_data.first;
         last_ff  <= req_data.last;
      end
   end

   // Entries never written read as zero width.
   always_ff @(posedge clock) begin
      if (reset) begin
         tvld_ff    <= '0;
         rdv_ff     <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
         if (acc_write) begin
            tvld_ff[req_data.code[TABLE_BITS-1:0]] <= 1'b1;
         end
         if (acc_glyph) begin
            rdv_ff <= tvld_ff[req_data.code[TABLE_BITS-1:0]];
         end
      end
   end

   assign fwd.valid      = f_valid_ff;
   assign fwd.item.cls   = cls_ff;
   assign fwd.item.code  = code_ff;
   assign fwd.item.width = rdv_ff ? rd_ff : 8'd0;
   assign fwd.item.first = first_ff;
   assign fwd.item.last  = last_ff;

endmodule

// ----- hdl/gll_queue.sv -----
// Two-entry queue between the front end and the layout back end.
// Depends on gll_pkg.
module gll_queue (
   input  logic              clock,
   input  logic              reset,
   input  gll_pkg::link_type push,
   output logic              q_ready,
   output gll_pkg::link_type head,
   input  logic              pop
);
   import gll_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ff;
   logic       wr_in;
   logic       rd_ff;
   logic       rd_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_push;
   logic       do_pop;

   assign q_ready = (cnt_ff != 2'd2);
   assign do_push = push.valid & q_ready;
   assign do_pop  = pop & (cnt_ff != 2'd0);

   assign wr_in  = do_push ? ~wr_ff : wr_ff;
   assign rd_in  = do_pop ? ~rd_ff : rd_ff;
   assign cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = slot_ff[rd_ff];

endmodule

// ----- hdl/gll_back.sv -----
// Back end: pen state, start registers and the layout decision for each glyph.
// Depends on gll_pkg.
module gll_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [gll_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [15:0]                      csr_wdata,
   input  gll_pkg::link_type                head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gll_pkg::rsp_type                 rsp_data
);
   import gll_pkg::*;

   localparam int PW = (COORD_BITS > 16) ? COORD_BITS : 16;
   // Largest pen coordinate, 2^(COORD_BITS-1)-1, one bit wider than the pen.
   localparam logic signed [PW:0] CMAX =
      {{(PW-COORD_BITS+2){1'b0}}, {(COORD_BITS-1){1'b1}}};

   logic signed [15:0]   start_x_ff;
   logic signed [15:0]   start_y_ff;
   logic signed [PW-1:0] pen_x_ff;
   logic signed [PW-1:0] pen_y_ff;
   logic                 term_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic signed [PW-1:0] sx;
   logic signed [PW-1:0] sy;
   logic signed [PW-1:0] px0;
   logic signed [PW-1:0] py0;
   logic                 t0;
   logic signed [PW:0]   sum_x;
   logic signed [PW:0]   sum_y;
   logic signed [PW-1:0] pen_x_in;
   logic signed [PW-1:0] pen_y_in;
   logic                 term_in;
   logic signed [PW-1:0] out_x;
   logic signed [PW-1:0] out_y;
   status_type           st;
   logic [4:0]           gw;
   logic                 trunc;
   item_type             it;

   assign it  = head.item;
   assign pop = head.valid & (~rsp_valid_ff | ~rsp_stall);

   assign sx  = PW'(start_x_ff);
   assign sy  = PW'(start_y_ff);
   assign px0 = it.first ? sx : pen_x_ff;
   assign py0 = it.first ? sy : pen_y_ff;
   assign t0  = it.first ? 1'b0 : term_ff;

   assign sum_x = (PW+1)'(px0) + $signed({{(PW-8){1'b0}}, 1'b0, it.width});
   assign sum_y = (PW+1)'(py0) + (PW+1)'(LINE_STEP);

   always_comb begin
      st       = ST_IGNORED;
      gw       = 5'd0;
      trunc    = 1'b0;
      term_in  = t0;
      pen_x_in = px0;
      pen_y_in = py0;
      out_x    = px0;
      out_y    = py0;
      if (!t0) begin
         unique case (it.cls)
            CLS_END: begin
               st      = ST_END;
               term_in = 1'b1;
            end
            CLS_UNSUP: begin
               st      = ST_UNSUPPORTED;
               term_in = 1'b1;
            end
            CLS_NEWLINE: begin
               if (sum_y > CMAX) begin
                  st      = ST_INVALID;
                  term_in = 1'b1;
               end else begin
                  st       = ST_LINE_BREAK;
                  pen_y_in = sum_y[PW-1:0];
                  pen_x_in = sx;
                  out_x    = sx;
                  out_y    = sum_y[PW-1:0];
                  trunc    = it.last;
                  term_in  = it.last;
               end
            end
            CLS_GLYPH: begin
               if (it.width == 8'd0 || it.width > MAX_WIDTH || sum_x > CMAX) begin
                  st      = ST_INVALID;
                  term_in = 1'b1;
               end else begin
                  st       = ST_PLACED;
                  gw       = it.width[4:0];
                  pen_x_in = sum_x[PW-1:0];
                  trunc    = it.last;
                  term_in  = it.last;
               end
            end
            default: begin
               st = ST_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_START_X: start_x_ff <= csr_wdata;
               CSR_START_Y: start_y_ff <= csr_wdata;
               default:     start_x_ff <= start_x_ff;
            endcase
         end
         if (pop) begin
            pen_x_ff <= pen_x_in;
            pen_y_ff <= pen_y_in;
            term_ff  <= term_in;
         end
         rsp_valid_ff <= pop | (rsp_valid_ff & rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff.status      <= st;
         rsp_ff.glyph       <= it.code;
         rsp_ff.pos_x       <= out_x[15:0];
         rsp_ff.pos_y       <= out_y[15:0];
         rsp_ff.glyph_width <= gw;
         rsp_ff.truncated   <= trunc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/glyph_line_layout.sv -----
// Glyph line layout: top level joining front end, queue and back end.
// Depends on gll_pkg, gll_front, gll_queue and gll_back.
//
// Usage: each request carries either a glyph byte (op 0) or a width table
// write (op 1). A glyph request yields exactly one response with its status
// and screen position; a table write yields none. The user must write
// start_x and start_y on the csr_ port (index 0 and 1) only while the
// block is idle; the block does not enforce this. A glyph reaches
// rsp_valid through table read, queue and layout register. Throughput is
// one request per cycle while rsp_stall is low, set by the single width
// table read and one pen add and compare per cycle in the back end. Reset
// clears the width table valid bits, so every width reads as zero, and
// clears the pen, the termination flag and the start registers. When the
// receiver stalls, the response holds and up to three more glyphs gather
// in the queue and front register before req_stall rises.
module glyph_line_layout #(
   parameter int COORD_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gll_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gll_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [gll_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [15:0]                      csr_wdata
);
   import gll_pkg::*;

   link_type fwd;
   link_type head;
   logic     q_ready;
   logic     pop;

   gll_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fwd       (fwd),
      .q_ready   (q_ready)
   );

   gll_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fwd),
      .q_ready (q_ready),
      .head    (head),
      .pop     (pop)
   );

   gll_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/gll_checker.sv -----
// Port-level checks for the glyph line layout block, bound to the top level.
// Depends on gll_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gll_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input gll_pkg::rsp_type rsp_data
);
   import gll_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_IMPLY(a_placed_width, clock, reset, rsp_valid && rsp_data.status == ST_PLACED, rsp_data.glyph_width != 5'd0 && rsp_data.glyph_width <= 5'd16)
   `ASSERT_IMPLY(a_term_clean, clock, reset, rsp_valid && (rsp_data.status == ST_END || rsp_data.status == ST_UNSUPPORTED || rsp_data.status == ST_INVALID || rsp_data.status == ST_IGNORED), !rsp_data.truncated && rsp_data.glyph_width == 5'd0)

endmodule

bind glyph_line_layout gll_checker u_gll_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
